### rtl/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg: shared types and constants of the square pulse channel
// Operation codes, register indexes, beat structs and the duty pattern table.
// ----------------------------------------------------------------------------
package spc_pkg;

  typedef enum logic [1:0] {
    ModeWrite   = 2'd0,
    ModeRead    = 2'd1,
    ModeTick    = 2'd2,
    ModeAdvance = 2'd3
  } spc_mode_e;

  typedef enum logic [1:0] {
    RegDuty     = 2'd0,
    RegEnvelope = 2'd1,
    RegPeriodLo = 2'd2,
    RegCtrl     = 2'd3
  } spc_reg_e;

  localparam int unsigned TimerW = 15;
  localparam int unsigned CalcW  = 17;  // headroom for subtract and reload

  localparam logic signed [11:0]       LevelHigh = 12'sd2000;
  localparam logic signed [11:0]       LevelLow  = -12'sd2000;
  localparam logic [11:0]              PeriodSpan = 12'd2048;
  localparam logic [6:0]               LengthFull = 7'd64;
  localparam logic [7:0]               ReadOpen   = 8'hFF;
  localparam logic signed [CalcW-1:0]  TimerMin   = -17'sd16384;
  localparam logic signed [CalcW-1:0]  TimerMax   = 17'sd16383;

  typedef struct packed {
    spc_mode_e  mode;
    spc_reg_e   reg_index;
    logic [7:0] write_data;
    logic [7:0] cycles;
  } spc_item_t;

  typedef struct packed {
    logic [7:0]        read_data;
    logic signed [11:0] sample;
    logic              channel_on;
  } spc_result_t;

  // Duty waveform, bit n is the level at step n.
  function automatic logic duty_bit(input logic [1:0] duty, input logic [2:0] step);
    logic [7:0] pat;
    case (duty)
      2'd0:    pat = 8'b1000_0000;
      2'd1:    pat = 8'b1000_0001;
      2'd2:    pat = 8'b1110_0001;
      default: pat = 8'b0111_1110;
    endcase
    return pat[step];
  endfunction

endpackage

### rtl/spc_core.sv
// ----------------------------------------------------------------------------
// spc_core: channel state and per-beat update
// Applies one operation to the channel state and forms its result.
// ----------------------------------------------------------------------------
module spc_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  spc_pkg::spc_item_t   item_i,
  output spc_pkg::spc_result_t result_o
);

  logic                                  en_q, en_d;
  logic [1:0]                            duty_q, duty_d;
  logic [5:0]                            len_load_q, len_load_d;
  logic [6:0]                            len_cnt_q, len_cnt_d;
  logic                                  len_on_q, len_on_d;
  logic [10:0]                           period_q, period_d;
  logic signed [spc_pkg::TimerW-1:0]     timer_q, timer_d;
  logic [2:0]                            step_q, step_d;
  logic signed [11:0]                    level_q, level_d;

  logic [7:0]                            rd;
  logic [13:0]                           reload;
  logic signed [spc_pkg::CalcW-1:0]      t_sub, t_new;

  assign reload = {spc_pkg::PeriodSpan - {1'b0, period_q}, 2'b00};
  assign t_sub  = spc_pkg::CalcW'(timer_q) - $signed({9'd0, item_i.cycles});

  always_comb begin
    en_d       = en_q;
    duty_d     = duty_q;
    len_load_d = len_load_q;
    len_cnt_d  = len_cnt_q;
    len_on_d   = len_on_q;
    period_d   = period_q;
    timer_d    = timer_q;
    step_d     = step_q;
    level_d    = level_q;
    rd         = 8'd0;
    t_new      = t_sub;

    case (item_i.mode)
      spc_pkg::ModeWrite: begin
        case (item_i.reg_index)
          spc_pkg::RegDuty: begin
            duty_d     = item_i.write_data[7:6];
            len_load_d = item_i.write_data[5:0];
          end
          spc_pkg::RegPeriodLo: begin
            period_d[7:0] = item_i.write_data;
          end
          spc_pkg::RegCtrl: begin
            if (item_i.write_data[7]) begin
              en_d      = 1'b1;
              step_d    = 3'd0;
              len_cnt_d = (len_load_q == 6'd0) ? spc_pkg::LengthFull
                                               : spc_pkg::LengthFull - {1'b0, len_load_q};
            end
            len_on_d       = item_i.write_data[6];
            period_d[10:8] = item_i.write_data[2:0];
          end
          default: ;  // envelope register has no effect
        endcase
      end
      spc_pkg::ModeRead: begin
        case (item_i.reg_index)
          spc_pkg::RegDuty: rd = {duty_q, 6'd0};
          spc_pkg::RegCtrl: rd = {1'b0, len_on_q, 6'd0};
          default:          rd = spc_pkg::ReadOpen;
        endcase
      end
      spc_pkg::ModeTick: begin
        if (en_q && len_on_q && (len_cnt_q != 7'd0)) begin
          len_cnt_d = len_cnt_q - 7'd1;
          if (len_cnt_q == 7'd1) en_d = 1'b0;
        end
      end
      default: begin  // advance
        if (en_q) begin
          if (t_sub <= 0) begin
            level_d = spc_pkg::duty_bit(duty_q, step_q) ? spc_pkg::LevelHigh
                                                         : spc_pkg::LevelLow;
            t_new   = t_sub + $signed({3'd0, reload});
            step_d  = step_q + 3'd1;
          end
          if (t_new < spc_pkg::TimerMin) t_new = spc_pkg::TimerMin;
          if (t_new > spc_pkg::TimerMax) t_new = spc_pkg::TimerMax;
          timer_d = t_new[spc_pkg::TimerW-1:0];
        end
      end
    endcase
  end

  assign result_o.read_data  = rd;
  assign result_o.sample     = en_d ? level_d : 12'sd0;
  assign result_o.channel_on = en_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q       <= 1'b0;
      duty_q     <= 2'd0;
      len_load_q <= 6'd0;
      len_cnt_q  <= 7'd0;
      len_on_q   <= 1'b0;
      period_q   <= 11'd0;
      timer_q    <= '0;
      step_q     <= 3'd0;
      level_q    <= 12'sd0;
    end else if (fire_i) begin
      en_q       <= en_d;
      duty_q     <= duty_d;
      len_load_q <= len_load_d;
      len_cnt_q  <= len_cnt_d;
      len_on_q   <= len_on_d;
      period_q   <= period_d;
      timer_q    <= timer_d;
      step_q     <= step_d;
      level_q    <= level_d;
    end
  end

endmodule

### rtl/square_pulse_channel.sv
// ----------------------------------------------------------------------------
// square_pulse_channel: square-wave sound channel behind four byte registers
// Register writes, reads, length ticks and cycle advances, one result each.
// ----------------------------------------------------------------------------
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  input   | in_valid_i, in_ready_o, mode_i, reg_index_i,    | in
//          | write_data_i, cycles_i                          |
//  output  | out_valid_o, out_ready_i, read_data_o,          | out
//          | sample_o, channel_on_o                          |
//
// Each beat passes through the input register, then through the channel
// update into the result register.
// A new beat is accepted every cycle while results are taken.
// A stall on the output holds the result register, and backs up into the
// input register; the input side stays ready while that register is free.
// Reset clears all channel state and both valid flags at once.
//
module square_pulse_channel (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [1:0]         reg_index_i,
  input  logic [7:0]         write_data_i,
  input  logic [7:0]         cycles_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         read_data_o,
  output logic signed [11:0] sample_o,
  output logic               channel_on_o
);

  // Input stage
  logic                 item_valid_q, item_valid_d;
  spc_pkg::spc_item_t   item_q;
  // Result stage
  logic                 out_valid_q, out_valid_d;
  spc_pkg::spc_result_t res_q, res_d;

  logic advance;  // result stage can take a new beat
  logic fire;     // input stage beat is applied to the channel this cycle

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = item_valid_q && advance;
  assign in_ready_o = !item_valid_q || advance;

  always_comb begin
    item_valid_d = item_valid_q;
    if (in_ready_o) item_valid_d = in_valid_i;
    out_valid_d = out_valid_q;
    if (advance) out_valid_d = item_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.mode       <= spc_pkg::spc_mode_e'(mode_i);
      item_q.reg_index  <= spc_pkg::spc_reg_e'(reg_index_i);
      item_q.write_data <= write_data_i;
      item_q.cycles     <= cycles_i;
    end
    if (fire) res_q <= res_d;
  end

  // Channel state and update logic
  spc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item_q),
    .result_o (res_d)
  );

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = res_q.read_data;
  assign sample_o     = res_q.sample;
  assign channel_on_o = res_q.channel_on;

endmodule

### tb/sv/tb_square_pulse_channel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_square_pulse_channel: self-checking bench for the square pulse channel
// Bus operations are queued up front, driven over valid/ready, and every
// result beat is checked against a cycle-free prediction of the channel.
// ----------------------------------------------------------------------------
module tb_square_pulse_channel;

  // Channel constants, kept local to the predictor.
  localparam int LEVEL_AMP  = 2000;
  localparam int PERIOD_TOP = 2048;
  localparam int LEN_FULL   = 64;
  localparam int TIMER_LO   = -16384;
  localparam int TIMER_HI   = 16383;

  // Duty waveforms, one byte per duty setting, step 0 in the byte's MSB.
  localparam logic [31:0] WAVE_TABLE = {8'b01111110, 8'b10000111,
                                        8'b10000001, 8'b00000001};

  localparam int RANDOM_OPS  = 550;
  localparam int QUIET_LIMIT = 4000;  // cycles with no beat on either side
  localparam int DRAIN_WAIT  = 8;     // two-stage pipe, plus margin

  // --------------------------------------------------------------------------
  // Clock, reset and DUT signals. Everything the bench drives starts at a known value.
  // --------------------------------------------------------------------------
  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_ready;
  logic [1:0]        mode         = 2'd0;
  logic [1:0]        reg_index    = 2'd0;
  logic [7:0]        write_data   = 8'd0;
  logic [7:0]        cycles       = 8'd0;
  logic              out_valid;
  logic              out_ready    = 1'b0;
  logic [7:0]        read_data;
  logic signed [11:0] sample;
  logic              channel_on;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  square_pulse_channel uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .mode_i      (mode),
    .reg_index_i (reg_index),
    .write_data_i(write_data),
    .cycles_i    (cycles),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .read_data_o (read_data),
    .sample_o    (sample),
    .channel_on_o(channel_on)
  );

  // --------------------------------------------------------------------------
  // Predicted channel state, starting from the reset values
  // --------------------------------------------------------------------------
  bit          ch_en    = 1'b0;
  logic [1:0]  duty_sel = 2'd0;
  logic [5:0]  len_load = 6'd0;
  int          len_cnt  = 0;
  bit          len_en   = 1'b0;
  logic [10:0] period   = 11'd0;
  int          timer    = 0;
  logic [2:0]  wave_pos = 3'd0;
  int          level    = 0;

  spc_pkg::spc_item_t   bus_ops_q[$];        // operations waiting to be driven
  spc_pkg::spc_result_t channel_results_q[$]; // predicted result beats, oldest first

  int total_ops;
  int sent_cnt   = 0;
  int recv_cnt   = 0;
  int fail_cnt   = 0;
  int quiet_cnt  = 0;
  int idle_phase = 0;  // 0 none, 1 sender idles, 2 receiver stalls, 3 both

  // Applies one bus operation to the predicted state and returns its result.
  function automatic spc_pkg::spc_result_t next_channel_result(input spc_pkg::spc_item_t op);
    spc_pkg::spc_result_t res;
    int t;
    res.read_data = 8'h00;
    case (op.mode)
      spc_pkg::ModeWrite: begin
        case (op.reg_index)
          spc_pkg::RegDuty: begin
            duty_sel = op.write_data[7:6];
            len_load = op.write_data[5:0];
          end
          spc_pkg::RegPeriodLo: period[7:0] = op.write_data;
          spc_pkg::RegCtrl: begin
            if (op.write_data[7]) begin
              // trigger: restart waveform and reload length, timer untouched
              ch_en    = 1'b1;
              wave_pos = 3'd0;
              len_cnt  = (len_load == 6'd0) ? LEN_FULL : LEN_FULL - int'(len_load);
            end
            len_en       = op.write_data[6];
            period[10:8] = op.write_data[2:0];
          end
          default: ;  // envelope register has no effect
        endcase
      end
      spc_pkg::ModeRead: begin
        case (op.reg_index)
          spc_pkg::RegDuty: res.read_data = {duty_sel, 6'b0};
          spc_pkg::RegCtrl: res.read_data = {1'b0, len_en, 6'b0};
          default:          res.read_data = 8'hFF;
        endcase
      end
      spc_pkg::ModeTick: begin
        if (ch_en && len_en && len_cnt > 0) begin
          len_cnt--;
          if (len_cnt == 0) ch_en = 1'b0;
        end
      end
      default: begin
        if (ch_en) begin
          t = timer - int'(op.cycles);
          if (t <= 0) begin
            level    = WAVE_TABLE[duty_sel * 8 + 7 - wave_pos] ? LEVEL_AMP : -LEVEL_AMP;
            t        = t + (PERIOD_TOP - int'(period)) * 4;
            wave_pos = wave_pos + 3'd1;
          end
          if (t < TIMER_LO) t = TIMER_LO;
          if (t > TIMER_HI) t = TIMER_HI;
          timer = t;
        end
      end
    endcase
    res.sample     = ch_en ? level[11:0] : 12'sd0;
    res.channel_on = ch_en;
    return res;
  endfunction

  function automatic void push_op(spc_pkg::spc_mode_e m, spc_pkg::spc_reg_e r,
                                  logic [7:0] wd, logic [7:0] cy);
    spc_pkg::spc_item_t op;
    op.mode       = m;
    op.reg_index  = r;
    op.write_data = wd;
    op.cycles     = cy;
    bus_ops_q.push_back(op);
  endfunction

  // Random content for the body of a well-formed sequence.
  function automatic void push_burst_op();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60)
      push_op(spc_pkg::ModeAdvance, spc_pkg::spc_reg_e'($urandom_range(0, 3)),
              8'($urandom_range(0, 255)),
              ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(0, 255)));
    else if (k < 76)
      push_op(spc_pkg::ModeTick, spc_pkg::spc_reg_e'($urandom_range(0, 3)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    else if (k < 89)
      push_op(spc_pkg::ModeRead, spc_pkg::spc_reg_e'($urandom_range(0, 3)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    else if (k < 94)
      push_op(spc_pkg::ModeWrite, spc_pkg::RegPeriodLo, 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
    else
      push_op(spc_pkg::ModeWrite, spc_pkg::spc_reg_e'($urandom_range(0, 3)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents queued ops, predicts each one as its beat is taken.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_blk
    bit                 took;
    bit                 gap;
    int                 pct;
    spc_pkg::spc_item_t cur;
    spc_pkg::spc_item_t nxt;
    if (rst_n) begin
      took = in_valid && in_ready;
      if (took) begin
        cur.mode       = spc_pkg::spc_mode_e'(mode);
        cur.reg_index  = spc_pkg::spc_reg_e'(reg_index);
        cur.write_data = write_data;
        cur.cycles     = cycles;
        channel_results_q.push_back(next_channel_result(cur));
        sent_cnt++;
      end
      idle_phase <= (sent_cnt * 4) / total_ops;
      pct = (idle_phase == 1) ? 55 : (idle_phase == 3) ? 7 : 0;
      gap = $urandom_range(0, 99) < pct;
      if (!in_valid || took) begin
        if (bus_ops_q.size() > 0 && !gap) begin
          nxt        = bus_ops_q.pop_front();
          mode       <= nxt.mode;
          reg_index  <= nxt.reg_index;
          write_data <= nxt.write_data;
          cycles     <= nxt.cycles;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result beat against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : mon_blk
    spc_pkg::spc_result_t exp_res;
    int                   pct;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        recv_cnt++;
        if (channel_results_q.size() == 0) begin
          $error("result beat with nothing expected: read_data=%0h sample=%0d on=%0b",
                 read_data, sample, channel_on);
          fail_cnt++;
        end else begin
          exp_res = channel_results_q.pop_front();
          if (read_data !== exp_res.read_data) begin
            $error("read_data: expected %0h, got %0h", exp_res.read_data, read_data);
            fail_cnt++;
          end
          if (sample !== exp_res.sample) begin
            $error("sample: expected %0d, got %0d", exp_res.sample, sample);
            fail_cnt++;
          end
          if (channel_on !== exp_res.channel_on) begin
            $error("channel_on: expected %0b, got %0b", exp_res.channel_on, channel_on);
            fail_cnt++;
          end
        end
      end
      pct = (idle_phase == 2) ? 55 : (idle_phase == 3) ? 7 : 0;
      out_ready <= !($urandom_range(0, 99) < pct);
    end
  end

  // Watchdog on stretches with no beat at all.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cnt <= 0;
      else quiet_cnt <= quiet_cnt + 1;
    end
  end

  initial begin
    while (quiet_cnt < QUIET_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stim_blk
    int n;
    int target;
    int sel;
    logic [7:0] ctl;

    // reset state visible through reads, and idle behavior while disabled
    push_op(spc_pkg::ModeRead, spc_pkg::RegDuty, 8'h00, 8'h00);
    push_op(spc_pkg::ModeRead, spc_pkg::RegEnvelope, 8'h00, 8'h00);
    push_op(spc_pkg::ModeRead, spc_pkg::RegPeriodLo, 8'h00, 8'h00);
    push_op(spc_pkg::ModeRead, spc_pkg::RegCtrl, 8'h00, 8'h00);
    push_op(spc_pkg::ModeAdvance, spc_pkg::RegDuty, 8'h00, 8'hFF);
    push_op(spc_pkg::ModeTick, spc_pkg::RegDuty, 8'h00, 8'h00);
    push_op(spc_pkg::ModeWrite, spc_pkg::RegEnvelope, 8'hFF, 8'hFF);
    // duty 3, longest load: one tick left after trigger; shortest period
    push_op(spc_pkg::ModeWrite, spc_pkg::RegDuty, 8'hFF, 8'h00);
    push_op(spc_pkg::ModeWrite, spc_pkg::RegPeriodLo, 8'hFF, 8'h00);
    push_op(spc_pkg::ModeWrite, spc_pkg::RegCtrl, 8'hC7, 8'h00);
    push_op(spc_pkg::ModeRead, spc_pkg::RegDuty, 8'h00, 8'h00);
    push_op(spc_pkg::ModeRead, spc_pkg::RegCtrl, 8'h00, 8'h00);
    push_op(spc_pkg::ModeAdvance, spc_pkg::RegDuty, 8'h00, 8'h00);
    push_op(spc_pkg::ModeAdvance, spc_pkg::RegDuty, 8'h00, 8'hFF);
    push_op(spc_pkg::ModeAdvance, spc_pkg::RegDuty, 8'h00, 8'h01);
    // length runs out, then a tick with the counter already at zero
    push_op(spc_pkg::ModeTick, spc_pkg::RegDuty, 8'h00, 8'h00);
    push_op(spc_pkg::ModeTick, spc_pkg::RegDuty, 8'h00, 8'h00);
    // duty 0, zero load means a full count; longest period, length off
    push_op(spc_pkg::ModeWrite, spc_pkg::RegDuty, 8'h00, 8'h00);
    push_op(spc_pkg::ModeWrite, spc_pkg::RegPeriodLo, 8'h00, 8'h00);
    push_op(spc_pkg::ModeWrite, spc_pkg::RegCtrl, 8'h80, 8'h00);
    push_op(spc_pkg::ModeTick, spc_pkg::RegDuty, 8'h00, 8'h00);
    push_op(spc_pkg::ModeAdvance, spc_pkg::RegDuty, 8'h00, 8'hFF);
    push_op(spc_pkg::ModeAdvance, spc_pkg::RegDuty, 8'h00, 8'hFF);
    // length on without a trigger
    push_op(spc_pkg::ModeWrite, spc_pkg::RegCtrl, 8'h47, 8'h00);
    push_op(spc_pkg::ModeRead, spc_pkg::RegCtrl, 8'h00, 8'h00);

    target = RANDOM_OPS;
    while (bus_ops_q.size() < target) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        // set up duty/length and period, trigger, then exercise the channel
        push_op(spc_pkg::ModeWrite, spc_pkg::RegDuty,
                ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                            : {2'($urandom_range(0, 3)),
                                               6'($urandom_range(56, 63))},
                8'($urandom_range(0, 255)));
        push_op(spc_pkg::ModeWrite, spc_pkg::RegPeriodLo, 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
        ctl = 8'($urandom_range(0, 255));
        ctl[7] = 1'b1;
        if ($urandom_range(0, 1) == 0) ctl[2:0] = 3'b111;
        push_op(spc_pkg::ModeWrite, spc_pkg::RegCtrl, ctl, 8'($urandom_range(0, 255)));
        n = $urandom_range(4, 30);
        repeat (n) push_burst_op();
      end else if (sel == 7) begin
        // very short period with long advances drives the timer to its floor
        push_op(spc_pkg::ModeWrite, spc_pkg::RegPeriodLo, 8'($urandom_range(248, 255)),
                8'h00);
        ctl = 8'($urandom_range(0, 255));
        ctl[7]   = 1'b1;
        ctl[6]   = 1'b0;
        ctl[2:0] = 3'b111;
        push_op(spc_pkg::ModeWrite, spc_pkg::RegCtrl, ctl, 8'($urandom_range(0, 255)));
        n = $urandom_range(70, 90);
        repeat (n) push_op(spc_pkg::ModeAdvance, spc_pkg::spc_reg_e'($urandom_range(0, 3)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(200, 255)));
        push_op(spc_pkg::ModeWrite, spc_pkg::RegPeriodLo, 8'h00, 8'h00);
        push_op(spc_pkg::ModeWrite, spc_pkg::RegCtrl, 8'h00, 8'h00);
        n = $urandom_range(2, 6);
        repeat (n) push_op(spc_pkg::ModeAdvance, spc_pkg::RegDuty, 8'h00, 8'hFF);
      end else begin
        // noise: any field value at all
        n = $urandom_range(1, 5);
        repeat (n) push_op(spc_pkg::spc_mode_e'($urandom_range(0, 3)),
                           spc_pkg::spc_reg_e'($urandom_range(0, 3)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
    end
    total_ops = bus_ops_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // sample at the falling edge, clear of the driver and monitor updates
    @(negedge clk);
    while (bus_ops_q.size() != 0 || in_valid || channel_results_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (fail_cnt == 0 && channel_results_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/spc_pkg.sv
rtl/spc_core.sv
rtl/square_pulse_channel.sv
tb/sv/tb_square_pulse_channel.sv
